// ===== rtl/core/sree_pkg.sv =====
`timescale 1ns / 1ps

package sree_pkg;

  // subrecord tags as read little-endian from the header
  localparam logic [31:0] TAG_LVLO       = 32'h4F4C_564C;
  localparam logic [31:0] TAG_KWDA       = 32'h4144_574B;
  localparam logic [15:0] ENTRY_MIN_SIZE = 16'd12;
  localparam logic [2:0]  HEADER_LAST    = 3'd5;

  // parser phase
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_DATA   = 2'd1;
  localparam logic [1:0] PH_STOP   = 2'd2;

  // what to do with the data of the current subrecord
  localparam logic [1:0] ACT_SKIP    = 2'd0;
  localparam logic [1:0] ACT_ENTRY   = 2'd1;
  localparam logic [1:0] ACT_KEYWORD = 2'd2;

  // result kinds
  localparam logic KIND_LEVELED = 1'b0;
  localparam logic KIND_KEYWORD = 1'b1;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [23:0] body_length;
    logic        is_leveled_list;
    logic        last_byte;
  } rec_item_t;

  typedef struct packed {
    logic        entry_kind;
    logic [31:0] form_id;
    logic [15:0] entry_level;
    logic [15:0] entry_count;
  } ent_item_t;

endpackage

// ===== rtl/core/subrecord_entry_extractor.sv =====
`timescale 1ns / 1ps

// Byte-serial subrecord parser. Record body bytes arrive on the rec channel, one per
// transfer, each carrying the body length, the leveled-list flag and a last-byte mark.
// The body is split into subrecords (6-byte little-endian header: 32-bit tag, 16-bit
// size). In a leveled-list body each LVLO subrecord of 12 bytes or more gives one
// entry (form id, level, count); in any other body each KWDA subrecord whose size is
// a multiple of 4 gives one keyword id per 4-byte word. Results leave on the ent
// channel. A header that does not fit, or a subrecord that would run past the body
// length, stops parsing until the last byte, after which the parser starts afresh.
// Throughput is one byte per clock while rec_ready is high: all parsing of a byte is
// done between the parser state registers and the result register, and a result shows
// up in the cycle after the byte that completes it. The result register is the only
// buffering, so rec_ready drops only while a result is held and ent_ready is low.
module subrecord_entry_extractor
  import sree_pkg::*;
#(
  parameter int OFFSET_WIDTH = 24
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      rec_valid,
  output logic      rec_ready,
  input  rec_item_t rec_data,
  output logic      ent_valid,
  input  logic      ent_ready,
  output ent_item_t ent_data
);

  // compare width: covers offset plus header or subrecord size without overflow
  localparam int CW = ((OFFSET_WIDTH > 24) ? OFFSET_WIDTH : 24) + 2;

  // parser state
  logic [1:0]              phase,         phase_next;
  logic [OFFSET_WIDTH-1:0] body_offset,   body_offset_next;
  logic [2:0]              header_index,  header_index_next;
  logic [31:0]             sub_tag,       sub_tag_next;
  logic [15:0]             sub_size,      sub_size_next;
  logic [15:0]             data_index,    data_index_next;
  logic [1:0]              sub_action,    sub_action_next;
  logic [31:0]             word_collect,  word_collect_next;
  logic [15:0]             level_collect, level_collect_next;

  logic      fire;
  logic      res_valid;
  ent_item_t res;

  logic [7:0]    b;
  logic [CW-1:0] o_ext;
  logic [CW-1:0] len_ext;
  logic [15:0]   size_full;
  logic          hdr_fits;
  logic          sub_fits;
  logic          data_done;

  // a new byte is taken whenever the result register is free or being emptied
  assign rec_ready = !ent_valid || ent_ready;
  assign fire      = rec_valid && rec_ready;

  assign b         = rec_data.data_byte;
  assign o_ext     = CW'(body_offset);
  assign len_ext   = CW'(rec_data.body_length);
  // size as it stands once the sixth header byte is in
  assign size_full = {b, sub_size[7:0]};
  assign hdr_fits  = (o_ext + CW'(6)) <= len_ext;
  assign sub_fits  = (o_ext + CW'(1) + CW'(size_full)) <= len_ext;
  assign data_done = ({1'b0, data_index} + 17'd1) >= {1'b0, sub_size};

  always_comb begin
    phase_next         = phase;
    body_offset_next   = body_offset;
    header_index_next  = header_index;
    sub_tag_next       = sub_tag;
    sub_size_next      = sub_size;
    data_index_next    = data_index;
    sub_action_next    = sub_action;
    word_collect_next  = word_collect;
    level_collect_next = level_collect;
    res_valid          = 1'b0;
    res                = '0;

    unique case (phase)
      PH_HEADER: begin
        if (header_index == 3'd0 && !hdr_fits) begin
          phase_next = PH_STOP;
        end else begin
          // tag and size are clear at header start, so each byte just fills its lane
          if (header_index < 3'd4) begin
            sub_tag_next[8*header_index[1:0] +: 8] = b;
          end else if (header_index == 3'd4) begin
            sub_size_next[7:0] = b;
          end else begin
            sub_size_next[15:8] = b;
          end

          if (header_index >= HEADER_LAST) begin
            header_index_next = 3'd0;
            if (!sub_fits) begin
              phase_next = PH_STOP;
            end else begin
              if (rec_data.is_leveled_list) begin
                sub_action_next = (sub_tag == TAG_LVLO && size_full >= ENTRY_MIN_SIZE)
                                  ? ACT_ENTRY : ACT_SKIP;
              end else begin
                sub_action_next = (sub_tag == TAG_KWDA && size_full[1:0] == 2'd0)
                                  ? ACT_KEYWORD : ACT_SKIP;
              end
              data_index_next    = '0;
              word_collect_next  = '0;
              level_collect_next = '0;
              sub_tag_next       = '0;
              if (size_full == 16'd0) begin
                // empty subrecord: straight on to the next header
                phase_next      = PH_HEADER;
                sub_action_next = ACT_SKIP;
              end else begin
                phase_next = PH_DATA;
              end
            end
          end else begin
            header_index_next = header_index + 3'd1;
          end
        end
      end

      PH_DATA: begin
        case (sub_action)
          ACT_ENTRY: begin
            if (data_index < 16'd4) begin
              word_collect_next[8*data_index[1:0] +: 8] = b;
            end else if (data_index == 16'd4) begin
              level_collect_next[7:0] = b;
            end else if (data_index == 16'd5) begin
              level_collect_next[15:8] = b;
            end else if (data_index == 16'd8) begin
              // low byte of the count is parked in the tag register
              sub_tag_next = {24'd0, b};
            end else if (data_index == 16'd9) begin
              res_valid       = 1'b1;
              res.entry_kind  = KIND_LEVELED;
              res.form_id     = word_collect;
              res.entry_level = level_collect;
              res.entry_count = {b, sub_tag[7:0]};
            end
          end
          ACT_KEYWORD: begin
            if (data_index[1:0] == 2'd0) begin
              word_collect_next = {24'd0, b};
            end else begin
              word_collect_next[8*data_index[1:0] +: 8] = b;
            end
            if (data_index[1:0] == 2'd3) begin
              res_valid       = 1'b1;
              res.entry_kind  = KIND_KEYWORD;
              res.form_id     = {b, word_collect[23:0]};
              res.entry_level = '0;
              res.entry_count = '0;
            end
          end
          default: begin
          end
        endcase

        if (data_done) begin
          phase_next        = PH_HEADER;
          header_index_next = 3'd0;
          sub_tag_next      = '0;
          sub_size_next     = '0;
          data_index_next   = '0;
          sub_action_next   = ACT_SKIP;
        end else begin
          data_index_next = data_index + 16'd1;
        end
      end

      default: begin
        // stopped: ignore bytes until the end of the body
      end
    endcase

    // offset saturates on very long bodies
    if (body_offset != {OFFSET_WIDTH{1'b1}}) begin
      body_offset_next = body_offset + OFFSET_WIDTH'(1);
    end

    // end of body: back to the initial state
    if (rec_data.last_byte) begin
      phase_next         = PH_HEADER;
      body_offset_next   = '0;
      header_index_next  = 3'd0;
      sub_tag_next       = '0;
      sub_size_next      = '0;
      data_index_next    = '0;
      sub_action_next    = ACT_SKIP;
      word_collect_next  = '0;
      level_collect_next = '0;
    end
  end

  // parser state registers, advanced once per accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      body_offset   <= '0;
      header_index  <= 3'd0;
      sub_tag       <= '0;
      sub_size      <= '0;
      data_index    <= '0;
      sub_action    <= ACT_SKIP;
      word_collect  <= '0;
      level_collect <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      body_offset   <= body_offset_next;
      header_index  <= header_index_next;
      sub_tag       <= sub_tag_next;
      sub_size      <= sub_size_next;
      data_index    <= data_index_next;
      sub_action    <= sub_action_next;
      word_collect  <= word_collect_next;
      level_collect <= level_collect_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
    end else if (fire && res_valid) begin
      ent_valid <= 1'b1;
    end else if (ent_ready) begin
      ent_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      ent_data <= res;
    end
  end

endmodule

// ===== bench/tb_subrecord_entry_extractor.sv =====
`timescale 1ns / 1ps

module tb_subrecord_entry_extractor;
  import sree_pkg::*;

  // body bytes wanted from the random part
  localparam int unsigned RANDOM_BYTES = 800;
  // cycles with no transfer on either channel before the run is abandoned
  localparam int unsigned STALL_LIMIT = 2000;
  // quiet cycles after the last entry, to catch stray results
  localparam int unsigned TAIL_CYCLES = 6;
  // lines of mismatch detail printed before going quiet
  localparam int unsigned REPORT_LINES = 40;

  logic      clk;
  logic      rst;
  logic      rec_valid;
  logic      rec_ready;
  rec_item_t rec_data;
  logic      ent_valid;
  logic      ent_ready = 1'b0;
  ent_item_t ent_data;

  // when set, neither side idles: back-to-back transfers
  bit          steady_flow = 1'b1;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  int unsigned mismatch_count;
  int unsigned checked_entries;
  int unsigned parsed_bytes;

  // entries the parser should emit, oldest first
  ent_item_t entries_due[$];
  // body under construction for the next send
  logic [7:0] body_bytes[$];

  // own copy of the parser state
  logic [1:0]  prs_phase;
  logic [23:0] byte_pos;
  logic [2:0]  hdr_idx;
  logic [31:0] tag_acc;
  logic [15:0] size_acc;
  logic [15:0] dat_idx;
  logic [1:0]  data_mode;
  logic [31:0] word_acc;
  logic [15:0] level_acc;

  subrecord_entry_extractor #(
    .OFFSET_WIDTH(24)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .rec_valid(rec_valid),
    .rec_ready(rec_ready),
    .rec_data (rec_data),
    .ent_valid(ent_valid),
    .ent_ready(ent_ready),
    .ent_data (ent_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // parser prediction
  // ---------------------------------------------------------------------------

  // state after reset and after every last byte
  function automatic void restart_parser();
    prs_phase = PH_HEADER;
    byte_pos  = '0;
    hdr_idx   = '0;
    tag_acc   = '0;
    size_acc  = '0;
    dat_idx   = '0;
    data_mode = ACT_SKIP;
    word_acc  = '0;
    level_acc = '0;
  endfunction

  // advance the parser by one accepted byte, queueing any entry it completes
  function automatic void parse_body_byte(input rec_item_t it);
    ent_item_t   res;
    logic [7:0]  b;
    b = it.data_byte;
    parsed_bytes++;

    if (prs_phase == PH_HEADER) begin
      // a header must fit entirely inside the body, else parsing halts
      if (hdr_idx == 0 && 32'(byte_pos) + 32'd6 > 32'(it.body_length)) begin
        prs_phase = PH_STOP;
      end else begin
        if (hdr_idx < 4) begin
          tag_acc |= 32'(b) << (8 * hdr_idx);
        end else begin
          size_acc |= 16'(b) << (8 * (hdr_idx - 4));
        end
        if (hdr_idx >= HEADER_LAST) begin
          hdr_idx = '0;
          // data running past the body length halts parsing too
          if (32'(byte_pos) + 32'd1 + 32'(size_acc) > 32'(it.body_length)) begin
            prs_phase = PH_STOP;
          end else begin
            // record kind is taken from the byte that completes the header
            if (it.is_leveled_list) begin
              data_mode = (tag_acc == TAG_LVLO && size_acc >= ENTRY_MIN_SIZE) ?
                          ACT_ENTRY : ACT_SKIP;
            end else begin
              data_mode = (tag_acc == TAG_KWDA && size_acc[1:0] == 2'b00) ?
                          ACT_KEYWORD : ACT_SKIP;
            end
            dat_idx   = '0;
            word_acc  = '0;
            level_acc = '0;
            tag_acc   = '0;
            // empty subrecord: straight on to the next header
            if (size_acc == 0) begin
              prs_phase = PH_HEADER;
              data_mode = ACT_SKIP;
            end else begin
              prs_phase = PH_DATA;
            end
          end
        end else begin
          hdr_idx++;
        end
      end
    end else if (prs_phase == PH_DATA) begin
      if (data_mode == ACT_ENTRY) begin
        // form id, level, then count split over bytes 8 and 9
        if (dat_idx < 4) begin
          word_acc |= 32'(b) << (8 * dat_idx);
        end else if (dat_idx < 6) begin
          level_acc |= 16'(b) << (8 * (dat_idx - 4));
        end else if (dat_idx == 8) begin
          tag_acc = 32'(b);
        end else if (dat_idx == 9) begin
          res.entry_kind  = KIND_LEVELED;
          res.form_id     = word_acc;
          res.entry_level = level_acc;
          res.entry_count = {b, tag_acc[7:0]};
          entries_due = {entries_due, res};
        end
      end else if (data_mode == ACT_KEYWORD) begin
        if (dat_idx[1:0] == 2'd0) word_acc = '0;
        word_acc |= 32'(b) << (8 * dat_idx[1:0]);
        if (dat_idx[1:0] == 2'd3) begin
          res.entry_kind  = KIND_KEYWORD;
          res.form_id     = word_acc;
          res.entry_level = '0;
          res.entry_count = '0;
          entries_due = {entries_due, res};
        end
      end
      if (32'(dat_idx) + 32'd1 >= 32'(size_acc)) begin
        prs_phase = PH_HEADER;
        hdr_idx   = '0;
        tag_acc   = '0;
        size_acc  = '0;
        dat_idx   = '0;
        data_mode = ACT_SKIP;
      end else begin
        dat_idx++;
      end
    end

    // offset saturates rather than wrapping
    if (byte_pos != '1) byte_pos++;
    if (it.last_byte) restart_parser();
  endfunction

  // ---------------------------------------------------------------------------
  // idling, sending and checking
  // ---------------------------------------------------------------------------

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_length();
    if ($urandom_range(0, 15) == 0) return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  // byte values lean towards the extremes
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // receiver stalls; held low for whole stretches at a time
  always @(posedge clk) begin : drive_ent_ready
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      ent_ready <= 1'b0;
    end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
      hold_left <= idle_length() - 1;
      ent_ready <= 1'b0;
    end else begin
      ent_ready <= 1'b1;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LINES) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  // one byte transfer; valid stays up across back-to-back bytes
  task automatic send_byte(input rec_item_t item);
    int unsigned gap;
    gap = steady_flow ? 0 : ($urandom_range(0, 2) == 0 ? idle_length() : 0);
    if (gap != 0) begin
      rec_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rec_valid <= 1'b1;
    rec_data  <= item;
    do @(posedge clk); while (!rec_ready);
    parse_body_byte(item);
  endtask

  // send the body built so far, last byte flagged; jitter varies the
  // per-body fields from byte to byte
  task automatic send_body(input logic lvl, input logic [23:0] len, input bit jitter);
    rec_item_t it;
    if (body_bytes.size() == 0) body_bytes = {body_bytes, rand_byte()};
    foreach (body_bytes[i]) begin
      it.data_byte       = body_bytes[i];
      it.body_length     = (jitter && $urandom_range(0, 3) == 0) ? 24'($urandom) : len;
      it.is_leveled_list = jitter ? 1'($urandom_range(0, 1)) : lvl;
      it.last_byte       = (i == body_bytes.size() - 1);
      send_byte(it);
    end
    body_bytes.delete();
  endtask

  task automatic add_header(input logic [31:0] tag, input logic [15:0] size);
    for (int i = 0; i < 4; i++) body_bytes = {body_bytes, tag[8*i +: 8]};
    body_bytes = {body_bytes, size[7:0]};
    body_bytes = {body_bytes, size[15:8]};
  endtask

  // every entry transfer is held against the oldest pending prediction
  always @(posedge clk) begin : check_results
    ent_item_t want;
    if (!rst && ent_valid && ent_ready) begin
      checked_entries++;
      if (entries_due.size() == 0) begin
        report_mismatch($sformatf("entry %0d arrived with none pending (form_id %h)",
                                  checked_entries, ent_data.form_id));
      end else begin
        want = entries_due.pop_front();
        if (ent_data.entry_kind !== want.entry_kind)
          report_mismatch($sformatf("entry %0d entry_kind %b, expected %b",
                                    checked_entries, ent_data.entry_kind, want.entry_kind));
        if (ent_data.form_id !== want.form_id)
          report_mismatch($sformatf("entry %0d form_id %h, expected %h",
                                    checked_entries, ent_data.form_id, want.form_id));
        if (ent_data.entry_level !== want.entry_level)
          report_mismatch($sformatf("entry %0d entry_level %h, expected %h",
                                    checked_entries, ent_data.entry_level, want.entry_level));
        if (ent_data.entry_count !== want.entry_count)
          report_mismatch($sformatf("entry %0d entry_count %h, expected %h",
                                    checked_entries, ent_data.entry_count, want.entry_count));
      end
    end
  end

  // a hung handshake ends the run
  always @(posedge clk) begin : watchdog
    if (rst || (rec_valid && rec_ready) || (ent_valid && ent_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("ERROR: no transfer for %0d cycles, %0d entries still pending",
               STALL_LIMIT, entries_due.size());
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // one LVLO entry of minimum size, every field at all ones, no idling
  task automatic test_leveled_entry();
    steady_flow = 1'b1;
    add_header(TAG_LVLO, ENTRY_MIN_SIZE);
    repeat (12) body_bytes = {body_bytes, 8'hFF};
    send_body(1'b1, 24'd18, 1'b0);
  endtask

  // one all-zero keyword, then a header that no longer fits the body
  task automatic test_keyword_cutoff();
    steady_flow = 1'b0;
    add_header(TAG_KWDA, 16'd4);
    repeat (4) body_bytes = {body_bytes, 8'h00};
    body_bytes = {body_bytes, 8'hA5};
    body_bytes = {body_bytes, 8'h5A};
    send_body(1'b0, 24'd12, 1'b0);
  endtask

  // tag: mostly the one the record kind wants, sometimes the other kind's,
  // a one-bit near miss or anything at all
  function automatic logic [31:0] pick_tag(input logic lvl);
    logic [31:0] good;
    good = lvl ? TAG_LVLO : TAG_KWDA;
    case ($urandom_range(0, 9))
      0: return lvl ? TAG_KWDA : TAG_LVLO;
      1: return good ^ (32'd1 << $urandom_range(0, 31));
      2: return $urandom;
      default: return good;
    endcase
  endfunction

  // size: mostly one that yields results, sometimes empty, short or ragged
  function automatic logic [15:0] pick_size(input logic lvl);
    case ($urandom_range(0, 7))
      0: return 16'($urandom_range(0, 3));
      1: return 16'($urandom_range(0, 15));
      default: return lvl ? 16'($urandom_range(12, 20)) : 16'(4 * $urandom_range(1, 4));
    endcase
  endfunction

  // mostly well-formed bodies with random content, with cut-short, padded
  // and over-claimed lengths mixed in, plus some plain noise
  task automatic test_random_bodies();
    logic        lvl;
    logic [23:0] len;
    logic [15:0] size;
    int unsigned start;
    start = parsed_bytes;
    while (parsed_bytes - start < RANDOM_BYTES) begin
      steady_flow = ($urandom_range(0, 5) == 0);
      lvl = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) < 2) begin
        repeat ($urandom_range(1, 20)) body_bytes = {body_bytes, rand_byte()};
        len = 24'($urandom_range(0, 24'hFF_FFFF));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          size = pick_size(lvl);
          add_header(pick_tag(lvl), size);
          repeat (size) body_bytes = {body_bytes, rand_byte()};
        end
        len = 24'(body_bytes.size());
        case ($urandom_range(0, 7))
          // length short of the bytes: a header or subrecord overruns it
          0: len = 24'($urandom_range(0, body_bytes.size() - 1));
          // trailing bytes, too few for a header or forming a junk one
          1: begin
            repeat ($urandom_range(1, 7)) body_bytes = {body_bytes, rand_byte()};
            len = 24'(body_bytes.size());
          end
          // length beyond the bytes: the last byte cuts parsing off
          2: len = len + 24'($urandom_range(1, 24'hFF_0000));
          default: ;
        endcase
      end
      send_body(lvl, len, $urandom_range(0, 19) == 0);
    end
  endtask

  initial begin : run_tests
    rst       <= 1'b1;
    rec_valid <= 1'b0;
    rec_data  <= '0;
    restart_parser();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_leveled_entry();
    test_keyword_cutoff();
    test_random_bodies();

    // drain: the watchdog bounds this wait
    rec_valid <= 1'b0;
    while (entries_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/sree_pkg.sv
rtl/core/subrecord_entry_extractor.sv
bench/tb_subrecord_entry_extractor.sv
